// File: rtl/turbo_rate_dematch_soft_combiner_defines.svh
// assertion macros shared by the rate dematching block
`ifndef TURBO_RATE_DEMATCH_SOFT_COMBINER_DEFINES_SVH
`define TURBO_RATE_DEMATCH_SOFT_COMBINER_DEFINES_SVH
`ifndef SYNTH
// checked property, off while reset is high
`define RTDM_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rtdm assertion failed");
// checked property, also during reset
`define RTDM_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) else $error("rtdm assertion failed");
`else
`define RTDM_ASSERT(label, prop)
`define RTDM_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: rtl/rtdm_pkg.sv
// types, constants and codes of the rate dematching block
`timescale 1ns / 1ps
package rtdm_pkg;
   localparam int MAX_ROWS_DEF = 193;
   localparam int COLS_PER_ROW = 96;
   localparam int DIV_W        = 22;
   localparam int DIV_CNT_W    = $clog2(DIV_W + 1);
   localparam int POS_W        = 15;
   localparam int E_W          = 20;
   localparam int SOFT_W       = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 22;

   // item codes
   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_LOAD   = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   // status codes
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_INVALID = 2'd1;
   localparam logic [1:0] STS_ZERO    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_BITS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_BLOCKS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOFT_BUF    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HARQ        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIMO        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MOD_ORDER   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYERS      = 3'd7;

   typedef enum logic [3:0] {
      ST_CLR_ALL, ST_IDLE, ST_DECODE, ST_DIV_GO, ST_DIV_WAIT, ST_E_MUL,
      ST_K_MUL, ST_CLR_BLK, ST_SCAN, ST_SCAN_CHK, ST_RD, ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      OP_SBS_MIMO, OP_NIR_M, OP_NCB, OP_TB_L, OP_GP_Q, OP_GP_C, OP_COLS, OP_K0
   } div_op_type;

   typedef enum logic [2:0] {
      RES_START_INV, RES_START_ZERO, RES_START_OK, RES_SAMPLE_FAIL,
      RES_SAMPLE_OK, RES_POS_BAD, RES_LOAD, RES_READ
   } res_type;

   typedef struct packed {
      logic       item_load;
      logic       scan_init;
      logic       scan_adv;
      logic       mem_rd;
      logic       rd_at_pos;
      logic       div_start;
      div_op_type div_op;
      logic       e_mul;
      logic       k_mul;
      logic       sweep_init;
      logic       clr_all_wr;
      logic       clr_blk_wr;
      logic       out_load;
      res_type    res_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] item_cmd;
      logic       item_clr;
      logic       cfg_bad;
      logic       sl_zero;
      logic       pos_bad;
      logic       div_done;
      logic       ncb_zero;
      logic       null_bit;
      logic       steps_last;
      logic       sweep_last_all;
      logic       sweep_last_blk;
      logic       out_free;
   } dp_status_type;
endpackage

// File: rtl/rtdm_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rtdm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rtdm_pkg::DIV_W-1:0] dividend,
   input  logic [rtdm_pkg::DIV_W-1:0] divisor,
   output logic                       done,
   output logic [rtdm_pkg::DIV_W-1:0] quotient,
   output logic [rtdm_pkg::DIV_W-1:0] remainder
);
   import rtdm_pkg::*;

   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [DIV_W:0]       shifted, diff;

   // one shift and trial subtract a step
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

// File: rtl/rtdm_datapath.sv
// registers, derivation arithmetic, buffer memories and result register
`timescale 1ns / 1ps
module rtdm_datapath #(
   parameter int MAX_ROWS = rtdm_pkg::MAX_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [1:0]                      req_cmd,
   input  logic [1:0]                      req_rv_index,
   input  logic [5:0]                      req_block_index,
   input  logic                            req_clear_buffer,
   input  logic signed [rtdm_pkg::SOFT_W-1:0] req_soft_value,
   input  logic [rtdm_pkg::POS_W-1:0]      req_position,
   input  logic                            req_null_flag,
   input  logic                            csr_valid,
   input  logic [rtdm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rtdm_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  rtdm_pkg::ctrl_cmd_type          cmd,
   output rtdm_pkg::dp_status_type         sts,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_status,
   output logic [rtdm_pkg::E_W-1:0]        rsp_e_count,
   output logic [rtdm_pkg::POS_W-1:0]      rsp_buffer_index,
   output logic signed [rtdm_pkg::SOFT_W-1:0] rsp_combined_value,
   output logic                            rsp_last
);
   import rtdm_pkg::*;

   localparam int DEPTH = COLS_PER_ROW * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);

   // configuration registers
   logic [7:0]  rc_ff;
   logic [19:0] tb_ff;
   logic [6:0]  cb_ff;
   logic [21:0] sbs_ff;
   logic [3:0]  hp_ff;
   logic [1:0]  mimo_ff;
   logic [3:0]  mod_ff;
   logic [2:0]  lay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff   <= 8'd1;
         tb_ff   <= '0;
         cb_ff   <= 7'd1;
         sbs_ff  <= '0;
         hp_ff   <= 4'd8;
         mimo_ff <= 2'd1;
         mod_ff  <= 4'd2;
         lay_ff  <= 3'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_COUNT:   rc_ff   <= csr_wdata[7:0];
            CSR_TOTAL_BITS:  tb_ff   <= csr_wdata[19:0];
            CSR_CODE_BLOCKS: cb_ff   <= csr_wdata[6:0];
            CSR_SOFT_BUF:    sbs_ff  <= csr_wdata[21:0];
            CSR_HARQ:        hp_ff   <= csr_wdata[3:0];
            CSR_MIMO:        mimo_ff <= csr_wdata[1:0];
            CSR_MOD_ORDER:   mod_ff  <= csr_wdata[3:0];
            CSR_LAYERS:      lay_ff  <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // latched input word
   logic [1:0]              it_cmd_ff, it_rv_ff;
   logic [5:0]              it_blk_ff;
   logic                    it_clr_ff, it_null_ff;
   logic signed [SOFT_W-1:0] it_soft_ff;
   logic [POS_W-1:0]        it_pos_ff;

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         it_cmd_ff  <= req_cmd;
         it_rv_ff   <= req_rv_index;
         it_blk_ff  <= req_block_index;
         it_clr_ff  <= req_clear_buffer;
         it_soft_ff <= req_soft_value;
         it_pos_ff  <= req_position;
         it_null_ff <= req_null_flag;
      end
   end

   // block state
   logic [POS_W-1:0] circ_ff, wp_ff, scan_ptr_ff, steps_ff;
   logic [E_W-1:0]   sl_ff;

   // derivation registers
   logic [DIV_W-1:0] tmp_ff;
   logic [POS_W-1:0] ncb_ff, k0_ff, prod_ff;
   logic [19:0]      qq_ff;
   logic [6:0]       g_ff, lq_ff;
   logic [3:0]       cols_ff;
   logic [E_W-1:0]   e_ff;

   logic [3:0]       m_lim;
   logic [POS_W-1:0] kw;
   logic [10:0]      rc8;
   logic [DIV_W-1:0] dvd, dvs, quo, rem;
   logic             div_done;

   assign m_lim = (hp_ff > 4'd8) ? 4'd8 : hp_ff;
   assign kw    = POS_W'(rc_ff) * POS_W'(COLS_PER_ROW);
   assign rc8   = {rc_ff, 3'b000};

   // divider operand selection
   always_comb begin
      unique case (cmd.div_op)
         OP_SBS_MIMO: begin dvd = sbs_ff; dvs = DIV_W'(mimo_ff); end
         OP_NIR_M:    begin dvd = tmp_ff; dvs = DIV_W'(m_lim); end
         OP_NCB:      begin dvd = tmp_ff; dvs = DIV_W'(cb_ff); end
         OP_TB_L:     begin dvd = DIV_W'(tb_ff); dvs = DIV_W'(lay_ff); end
         OP_GP_Q:     begin dvd = tmp_ff; dvs = DIV_W'(mod_ff); end
         OP_GP_C:     begin dvd = tmp_ff; dvs = DIV_W'(cb_ff); end
         OP_COLS: begin
            dvd = DIV_W'(ncb_ff) + DIV_W'(rc8) - DIV_W'(1);
            dvs = DIV_W'(rc8);
         end
         OP_K0:       begin dvd = DIV_W'(prod_ff); dvs = DIV_W'(ncb_ff); end
         default:     begin dvd = tmp_ff; dvs = DIV_W'(1); end
      endcase
   end

   rtdm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dvd),
      .divisor   (dvs),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   // e and k0 helpers
   logic        bump;
   logic [27:0] e_full;
   logic [5:0]  term;
   logic [6:0]  fac;

   assign bump   = (7'(it_blk_ff) < (cb_ff - g_ff)) ? 1'b0 : (g_ff != 7'd0);
   assign e_full = 28'(lq_ff) * 28'({1'b0, qq_ff} + 21'(bump));
   assign term   = (it_rv_ff[0] ? 6'(cols_ff) : 6'd0)
                 + (it_rv_ff[1] ? 6'({cols_ff, 1'b0}) : 6'd0);
   assign fac    = 7'd2 + {term, 1'b0};

   // capture divider results and products
   always_ff @(posedge clock) begin
      lq_ff <= 7'(lay_ff) * 7'(mod_ff);
      if (div_done) begin
         unique case (cmd.div_op)
            OP_SBS_MIMO, OP_NIR_M, OP_TB_L, OP_GP_Q: tmp_ff <= quo;
            OP_NCB:  ncb_ff <= (quo > DIV_W'(kw)) ? kw : quo[POS_W-1:0];
            OP_GP_C: begin
               qq_ff <= quo[19:0];
               g_ff  <= rem[6:0];
            end
            OP_COLS: cols_ff <= quo[3:0];
            OP_K0:   k0_ff   <= rem[POS_W-1:0];
            default: ;
         endcase
      end
      if (cmd.e_mul) e_ff <= e_full[E_W-1:0];
      if (cmd.k_mul) prod_ff <= POS_W'(rc_ff) * POS_W'(fac);
   end

   // clearing sweep counter
   logic [AW-1:0] sw_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.sweep_init) sw_ff <= '0;
      else if (cmd.clr_all_wr || cmd.clr_blk_wr) sw_ff <= sw_ff + 1'b1;
   end

   // null scan pointer
   logic [POS_W-1:0] scan_next;

   assign scan_next = (scan_ptr_ff + 1'b1 == circ_ff) ? '0 : scan_ptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         scan_ptr_ff <= wp_ff;
         steps_ff    <= '0;
      end else if (cmd.scan_adv) begin
         scan_ptr_ff <= scan_next;
         steps_ff    <= steps_ff + 1'b1;
      end
   end

   // buffer and null map memories
   logic signed [SOFT_W-1:0] buf_mem [DEPTH];
   logic                     nm_mem  [DEPTH];
   logic signed [SOFT_W-1:0] buf_rd_ff, buf_wdata;
   logic                     nm_rd_ff, buf_we, nm_we, nm_wdata;
   logic [AW-1:0]            buf_waddr, nm_waddr, buf_raddr;
   logic signed [SOFT_W:0]   sum_wide;
   logic signed [SOFT_W-1:0] sum_sat;

   // saturating combine
   always_comb begin
      sum_wide = {buf_rd_ff[SOFT_W-1], buf_rd_ff} + {it_soft_ff[SOFT_W-1], it_soft_ff};
      if (sum_wide > 17'sd32767) sum_sat = 16'sh7FFF;
      else if (sum_wide < -17'sd32768) sum_sat = 16'sh8000;
      else sum_sat = sum_wide[SOFT_W-1:0];
   end

   assign buf_we    = cmd.clr_all_wr || cmd.clr_blk_wr
                    || (cmd.out_load && cmd.res_sel == RES_SAMPLE_OK);
   assign buf_waddr = (cmd.clr_all_wr || cmd.clr_blk_wr) ? sw_ff : scan_ptr_ff[AW-1:0];
   assign buf_wdata = (cmd.clr_all_wr || cmd.clr_blk_wr) ? '0 : sum_sat;
   assign nm_we     = cmd.clr_all_wr || (cmd.out_load && cmd.res_sel == RES_LOAD);
   assign nm_waddr  = cmd.clr_all_wr ? sw_ff : it_pos_ff[AW-1:0];
   assign nm_wdata  = cmd.clr_all_wr ? 1'b0 : it_null_ff;
   assign buf_raddr = cmd.rd_at_pos ? it_pos_ff[AW-1:0] : scan_ptr_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (buf_we) buf_mem[buf_waddr] <= buf_wdata;
      if (cmd.mem_rd) buf_rd_ff <= buf_mem[buf_raddr];
   end

   always_ff @(posedge clock) begin
      if (nm_we) nm_mem[nm_waddr] <= nm_wdata;
      if (cmd.mem_rd) nm_rd_ff <= nm_mem[scan_ptr_ff[AW-1:0]];
   end

   // block state and result register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         circ_ff      <= '0;
         wp_ff        <= '0;
         sl_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (cmd.out_load) begin
            unique case (cmd.res_sel)
               RES_START_INV: sl_ff <= '0;
               RES_START_ZERO: begin
                  sl_ff   <= '0;
                  circ_ff <= '0;
                  wp_ff   <= '0;
               end
               RES_START_OK: begin
                  sl_ff   <= e_ff;
                  circ_ff <= ncb_ff;
                  wp_ff   <= k0_ff;
               end
               RES_SAMPLE_OK: begin
                  sl_ff <= sl_ff - 1'b1;
                  wp_ff <= scan_next;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_combined_value <= '0;
         rsp_last           <= 1'b0;
         unique case (cmd.res_sel)
            RES_START_INV: begin
               rsp_status       <= STS_INVALID;
               rsp_e_count      <= '0;
               rsp_buffer_index <= '0;
            end
            RES_START_ZERO: begin
               rsp_status       <= STS_ZERO;
               rsp_e_count      <= e_ff;
               rsp_buffer_index <= '0;
            end
            RES_START_OK: begin
               rsp_status       <= STS_OK;
               rsp_e_count      <= e_ff;
               rsp_buffer_index <= k0_ff;
            end
            RES_SAMPLE_FAIL: begin
               rsp_status       <= STS_INVALID;
               rsp_e_count      <= sl_ff;
               rsp_buffer_index <= wp_ff;
            end
            RES_SAMPLE_OK: begin
               rsp_status         <= STS_OK;
               rsp_e_count        <= sl_ff - 1'b1;
               rsp_buffer_index   <= scan_ptr_ff;
               rsp_combined_value <= sum_sat;
               rsp_last           <= (sl_ff == E_W'(1));
            end
            RES_POS_BAD: begin
               rsp_status       <= STS_INVALID;
               rsp_e_count      <= sl_ff;
               rsp_buffer_index <= it_pos_ff;
            end
            RES_LOAD: begin
               rsp_status       <= STS_OK;
               rsp_e_count      <= sl_ff;
               rsp_buffer_index <= it_pos_ff;
            end
            RES_READ: begin
               rsp_status         <= STS_OK;
               rsp_e_count        <= sl_ff;
               rsp_buffer_index   <= it_pos_ff;
               rsp_combined_value <= buf_rd_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // status towards the controller
   always_comb begin
      sts.item_cmd       = it_cmd_ff;
      sts.item_clr       = it_clr_ff;
      sts.cfg_bad        = (cb_ff == '0) || (hp_ff == '0) || (mimo_ff == '0)
                        || (mod_ff == '0) || (lay_ff == '0) || (rc_ff == '0)
                        || (rc_ff > 8'(MAX_ROWS));
      sts.sl_zero        = (sl_ff == '0);
      sts.pos_bad        = (it_pos_ff >= POS_W'(DEPTH));
      sts.div_done       = div_done;
      sts.ncb_zero       = (ncb_ff == '0);
      sts.null_bit       = nm_rd_ff;
      sts.steps_last     = (steps_ff + 1'b1 == circ_ff);
      sts.sweep_last_all = (sw_ff == AW'(DEPTH - 1));
      sts.sweep_last_blk = (POS_W'(sw_ff) == ncb_ff - 1'b1);
      sts.out_free       = !rsp_valid_ff || rsp_ready;
   end
endmodule

// File: rtl/rtdm_ctrl.sv
// controller state machine sequencing start, sample, load and read words
`timescale 1ns / 1ps
`include "turbo_rate_dematch_soft_combiner_defines.svh"
module rtdm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rtdm_pkg::dp_status_type sts,
   output rtdm_pkg::ctrl_cmd_type  cmd
);
   import rtdm_pkg::*;

   state_type  state_ff, state_in;
   div_op_type op_ff, op_in;
   res_type    res_ff, res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR_ALL;
         op_ff    <= OP_SBS_MIMO;
         res_ff   <= RES_START_INV;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         res_ff   <= res_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      res_in     = res_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.div_op = op_ff;
      cmd.res_sel = res_ff;
      unique case (state_ff)
         ST_CLR_ALL: begin
            cmd.clr_all_wr = 1'b1;
            if (sts.sweep_last_all) begin
               cmd.sweep_init = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.item_load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (sts.item_cmd)
               CMD_START: begin
                  if (sts.cfg_bad) begin
                     res_in   = RES_START_INV;
                     state_in = ST_FIN;
                  end else begin
                     op_in    = OP_SBS_MIMO;
                     state_in = ST_DIV_GO;
                  end
               end
               CMD_SAMPLE: begin
                  if (sts.sl_zero) begin
                     res_in   = RES_SAMPLE_FAIL;
                     state_in = ST_FIN;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in = ST_SCAN;
                  end
               end
               CMD_LOAD: begin
                  res_in   = sts.pos_bad ? RES_POS_BAD : RES_LOAD;
                  state_in = ST_FIN;
               end
               CMD_READ: begin
                  if (sts.pos_bad) begin
                     res_in   = RES_POS_BAD;
                     state_in = ST_FIN;
                  end else begin
                     state_in = ST_RD;
                  end
               end
               default: ;
            endcase
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (sts.div_done) begin
               unique case (op_ff)
                  OP_SBS_MIMO: begin op_in = OP_NIR_M; state_in = ST_DIV_GO; end
                  OP_NIR_M:    begin op_in = OP_NCB;   state_in = ST_DIV_GO; end
                  OP_NCB:      begin op_in = OP_TB_L;  state_in = ST_DIV_GO; end
                  OP_TB_L:     begin op_in = OP_GP_Q;  state_in = ST_DIV_GO; end
                  OP_GP_Q:     begin op_in = OP_GP_C;  state_in = ST_DIV_GO; end
                  OP_GP_C:     state_in = ST_E_MUL;
                  OP_COLS:     state_in = ST_K_MUL;
                  OP_K0: begin
                     if (sts.item_clr) begin
                        cmd.sweep_init = 1'b1;
                        state_in = ST_CLR_BLK;
                     end else begin
                        res_in   = RES_START_OK;
                        state_in = ST_FIN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_E_MUL: begin
            cmd.e_mul = 1'b1;
            if (sts.ncb_zero) begin
               res_in   = RES_START_ZERO;
               state_in = ST_FIN;
            end else begin
               op_in    = OP_COLS;
               state_in = ST_DIV_GO;
            end
         end
         ST_K_MUL: begin
            cmd.k_mul = 1'b1;
            op_in     = OP_K0;
            state_in  = ST_DIV_GO;
         end
         ST_CLR_BLK: begin
            cmd.clr_blk_wr = 1'b1;
            if (sts.sweep_last_blk) begin
               cmd.sweep_init = 1'b1;
               res_in   = RES_START_OK;
               state_in = ST_FIN;
            end
         end
         ST_SCAN: begin
            cmd.mem_rd = 1'b1;
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (!sts.null_bit) begin
               res_in   = RES_SAMPLE_OK;
               state_in = ST_FIN;
            end else if (sts.steps_last) begin
               res_in   = RES_SAMPLE_FAIL;
               state_in = ST_FIN;
            end else begin
               cmd.scan_adv = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_RD: begin
            cmd.mem_rd    = 1'b1;
            cmd.rd_at_pos = 1'b1;
            res_in   = RES_READ;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // checks
   `RTDM_ASSERT(a_accept_decodes, (req_valid && req_ready) |=> (state_ff == ST_DECODE))
   `RTDM_ASSERT(a_div_go_waits, cmd.div_start |=> (state_ff == ST_DIV_WAIT))
   `RTDM_ASSERT(a_load_when_free, cmd.out_load |-> sts.out_free)
   `RTDM_ASSERT(a_no_clear_on_sample, cmd.clr_blk_wr |-> (sts.item_cmd == CMD_START))
endmodule

// File: rtl/turbo_rate_dematch_soft_combiner.sv
// top level of the turbo rate dematching and soft combining block
//
// Usage:
//   req_* carries one word per handshake: a start (redundancy version, block
//   number, clear flag), a soft sample, a null-map load or a buffer readback.
//   rsp_* returns exactly one word for each request word.
//   csr_* writes the eight configuration registers; csr_ready is always high.
// Sequencing:
//   words are handled one at a time; a sample first steps past any null
//   positions, and the next word is taken in the cycle after a result is
//   loaded. A start runs the shared one-bit-per-step divider up to eight
//   times (six when the circular buffer length is zero), plus a clearing
//   pass over the block's entries when the clear flag is set.
// Reset:
//   synchronous; then a clearing pass over 96*MAX_ROWS entries (18528 at
//   the default) zeroes the buffer and null map, with req_ready held low.
// Stall:
//   the result register holds while rsp_ready is low; the next request word
//   is taken meanwhile and its result waits until the register frees.
`timescale 1ns / 1ps
module turbo_rate_dematch_soft_combiner #(
   parameter int MAX_ROWS = rtdm_pkg::MAX_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_cmd,
   input  logic [1:0]                      req_rv_index,
   input  logic [5:0]                      req_block_index,
   input  logic                            req_clear_buffer,
   input  logic signed [rtdm_pkg::SOFT_W-1:0] req_soft_value,
   input  logic [rtdm_pkg::POS_W-1:0]      req_position,
   input  logic                            req_null_flag,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic [rtdm_pkg::E_W-1:0]        rsp_e_count,
   output logic [rtdm_pkg::POS_W-1:0]      rsp_buffer_index,
   output logic signed [rtdm_pkg::SOFT_W-1:0] rsp_combined_value,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rtdm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rtdm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rtdm_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   assign csr_ready = 1'b1;

   rtdm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rtdm_datapath #(
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_cmd),
      .req_rv_index       (req_rv_index),
      .req_block_index    (req_block_index),
      .req_clear_buffer   (req_clear_buffer),
      .req_soft_value     (req_soft_value),
      .req_position       (req_position),
      .req_null_flag      (req_null_flag),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_e_count        (rsp_e_count),
      .rsp_buffer_index   (rsp_buffer_index),
      .rsp_combined_value (rsp_combined_value),
      .rsp_last           (rsp_last)
   );
endmodule

// File: tb/sv/tb.sv
// testbench for the turbo rate dematching and soft combining block
`timescale 1ns / 1ps
module tb;
   import rtdm_pkg::*;

   localparam int DEPTH = COLS_PER_ROW * MAX_ROWS_DEF;

   typedef struct packed {
      logic [1:0]        status;
      logic [E_W-1:0]    e_count;
      logic [POS_W-1:0]  index;
      logic [SOFT_W-1:0] value;
      logic              last;
   } word_type;

   // one row of stimulus: a request word or a register write
   typedef struct {
      bit                      is_csr;
      logic [CSR_IDX_W-1:0]    idx;
      logic [CSR_DATA_W-1:0]   data;
      logic [1:0]              cmd;
      logic [1:0]              rv;
      logic [5:0]              blk;
      logic                    clr;
      logic signed [SOFT_W-1:0] soft_val;
      logic [POS_W-1:0]        pos;
      logic                    nflag;
      bit                      has_exp;
      word_type                exp_word;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic [1:0] req_cmd = '0, req_rv_index = '0;
   logic [5:0] req_block_index = '0;
   logic req_clear_buffer = 0, req_null_flag = 0;
   logic signed [SOFT_W-1:0] req_soft_value = '0;
   logic [POS_W-1:0] req_position = '0;
   logic rsp_valid, rsp_ready = 0;
   logic [1:0] rsp_status;
   logic [E_W-1:0] rsp_e_count;
   logic [POS_W-1:0] rsp_buffer_index;
   logic signed [SOFT_W-1:0] rsp_combined_value;
   logic rsp_last;
   logic csr_valid = 0, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   logic signed [SOFT_W-1:0] soft_mem [DEPTH];
   bit null_mem [DEPTH];
   int unsigned wr_ptr, circ_len, samples_left;
   int unsigned rows, tot_bits, n_blocks, sbuf, harq, mimo, qm, layers;

   word_type expected_words[$];
   int err_cnt = 0;
   int accepted = 0;
   int snd_pct = 10, rcv_pct = 65;
   bit hold_req = 0;
   int hold_left = 0;

   turbo_rate_dematch_soft_combiner u_top (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   initial begin
      #20000000;
      $display("DONE: errors detected");
      $finish;
   end

   // receiver: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req = 0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      word_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_e_count, rsp_buffer_index, rsp_combined_value, rsp_last};
         if (expected_words.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10) $display("unexpected result word %p", got);
         end else begin
            want = expected_words.pop_front();
            if (got.status !== want.status || got.e_count !== want.e_count ||
                got.index !== want.index || got.value !== want.value ||
                got.last !== want.last) begin
               err_cnt++;
               if (err_cnt <= 10)
                  $display("mismatch: exp st %0d e %0d idx %0d val %0d last %0d / got st %0d e %0d idx %0d val %0d last %0d",
                           want.status, want.e_count, want.index, $signed(want.value),
                           want.last, got.status, got.e_count, got.index,
                           $signed(got.value), got.last);
            end
         end
      end
   end

   function automatic void reset_model();
      rows = 1; tot_bits = 0; n_blocks = 1; sbuf = 0;
      harq = 8; mimo = 1; qm = 2; layers = 1;
      foreach (soft_mem[i]) soft_mem[i] = '0;
      foreach (null_mem[i]) null_mem[i] = 0;
      wr_ptr = 0; circ_len = 0; samples_left = 0;
   endfunction

   // expected result of one word, updating the predictor state
   function automatic word_type dematch_predict(row_type r);
      word_type o;
      int unsigned m, nir, kw, ncb, gp, g, q, e, cols, k0, p, steps;
      int sum;
      o = '0;
      case (r.cmd)
         CMD_START: begin
            samples_left = 0;
            if (n_blocks == 0 || harq == 0 || mimo == 0 || qm == 0 || layers == 0 ||
                rows == 0 || rows > MAX_ROWS_DEF) begin
               o.status = STS_INVALID;
               return o;
            end
            m = (harq < 8) ? harq : 8;
            nir = sbuf / mimo / m;
            kw = COLS_PER_ROW * rows;
            ncb = nir / n_blocks;
            if (ncb > kw) ncb = kw;
            gp = tot_bits / layers / qm;
            g = gp % n_blocks;
            q = gp / n_blocks;
            if (r.blk < n_blocks - g) e = layers * qm * q;
            else e = layers * qm * (q + (g != 0));
            o.e_count = e[E_W-1:0];
            if (ncb == 0) begin
               circ_len = 0;
               wr_ptr = 0;
               o.status = STS_ZERO;
               return o;
            end
            cols = (ncb + 8 * rows - 1) / (8 * rows);
            k0 = (rows * (2 + 2 * r.rv * cols)) % ncb;
            if (r.clr)
               for (int i = 0; i < ncb; i++) soft_mem[i] = '0;
            circ_len = ncb;
            wr_ptr = k0;
            samples_left = e;
            o.status = STS_OK;
            o.index = k0[POS_W-1:0];
         end
         CMD_SAMPLE: begin
            o.status = STS_INVALID;
            o.e_count = samples_left[E_W-1:0];
            o.index = wr_ptr[POS_W-1:0];
            if (samples_left == 0 || circ_len == 0 || circ_len > DEPTH || wr_ptr >= circ_len)
               return o;
            p = wr_ptr;
            steps = 0;
            while (null_mem[p] && steps < circ_len) begin
               p = (p + 1 == circ_len) ? 0 : p + 1;
               steps++;
            end
            if (steps == circ_len) return o;
            sum = int'(soft_mem[p]) + int'(r.soft_val);
            if (sum > 32767) sum = 32767;
            else if (sum < -32768) sum = -32768;
            soft_mem[p] = sum[SOFT_W-1:0];
            samples_left--;
            wr_ptr = (p + 1 == circ_len) ? 0 : p + 1;
            o = '{STS_OK, samples_left[E_W-1:0], p[POS_W-1:0], sum[SOFT_W-1:0],
                  samples_left == 0};
         end
         default: begin
            o.e_count = samples_left[E_W-1:0];
            o.index = r.pos;
            if (r.pos >= DEPTH) o.status = STS_INVALID;
            else if (r.cmd == CMD_LOAD) null_mem[r.pos] = r.nflag;
            else o.value = soft_mem[r.pos];
         end
      endcase
      return o;
   endfunction

   function automatic row_type mk_word(int cmd, int rv, int blk, int clr, int soft_val,
                                       int pos, int nflag);
      row_type r;
      r = '{default: '0};
      r.cmd = cmd[1:0]; r.rv = rv[1:0]; r.blk = blk[5:0]; r.clr = clr[0];
      r.soft_val = soft_val[SOFT_W-1:0]; r.pos = pos[POS_W-1:0]; r.nflag = nflag[0];
      return r;
   endfunction

   function automatic row_type with_exp(row_type r, logic [1:0] st, int e, int idx, int val);
      r.has_exp = 1;
      r.exp_word = '{st, e[E_W-1:0], idx[POS_W-1:0], val[SOFT_W-1:0], 1'b0};
      return r;
   endfunction

   function automatic row_type mk_csr(logic [CSR_IDX_W-1:0] idx, int data);
      row_type r;
      r = '{default: '0};
      r.is_csr = 1; r.idx = idx; r.data = data[CSR_DATA_W-1:0];
      return r;
   endfunction

   // offer one word and wait for it to be taken
   task automatic send_word(row_type r);
      word_type w;
      req_valid <= 1;
      req_cmd <= r.cmd; req_rv_index <= r.rv; req_block_index <= r.blk;
      req_clear_buffer <= r.clr; req_soft_value <= r.soft_val;
      req_position <= r.pos; req_null_flag <= r.nflag;
      do @(posedge clock); while (!req_ready);
      w = dematch_predict(r);
      expected_words.push_back(r.has_exp ? r.exp_word : w);
      accepted++;
      if (accepted == 350) begin snd_pct = 65; rcv_pct = 10; end
      if (accepted == 700) begin snd_pct = 0; rcv_pct = 0; end
      if ($urandom_range(99) < snd_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // let the block drain before touching registers
   task automatic drain();
      req_valid <= 0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         CSR_ROW_COUNT:   rows = data & 8'hFF;
         CSR_TOTAL_BITS:  tot_bits = data & 20'hFFFFF;
         CSR_CODE_BLOCKS: n_blocks = data & 7'h7F;
         CSR_SOFT_BUF:    sbuf = data & 22'h3FFFFF;
         CSR_HARQ:        harq = data & 4'hF;
         CSR_MIMO:        mimo = data & 2'h3;
         CSR_MOD_ORDER:   qm = data & 4'hF;
         default:         layers = data & 3'h7;
      endcase
   endtask

   initial begin
      row_type dir_rows[$];
      int unsigned c_rows, c_l, c_q, c_c, c_per, c_tot, c_sbuf, n, nsmp, ncb;
      bit did_null, did_hold, did_wait;
      reset_model();
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed: defaults, out-of-range positions, invalid settings, saturation
      dir_rows.push_back(with_exp(mk_word(CMD_START, 0, 0, 0, 0, 0, 0), STS_ZERO, 0, 0, 0));
      dir_rows.push_back(with_exp(mk_word(CMD_SAMPLE, 0, 0, 0, 5, 0, 0), STS_INVALID, 0, 0, 0));
      dir_rows.push_back(with_exp(mk_word(CMD_LOAD, 0, 0, 0, 0, DEPTH, 1),
                                  STS_INVALID, 0, DEPTH, 0));
      dir_rows.push_back(with_exp(mk_word(CMD_READ, 3, 63, 1, -1, 32767, 1),
                                  STS_INVALID, 0, 32767, 0));
      dir_rows.push_back(with_exp(mk_word(CMD_LOAD, 0, 0, 0, 0, DEPTH - 1, 1),
                                  STS_OK, 0, DEPTH - 1, 0));
      dir_rows.push_back(with_exp(mk_word(CMD_READ, 0, 0, 0, 0, DEPTH - 1, 0),
                                  STS_OK, 0, DEPTH - 1, 0));
      dir_rows.push_back(mk_csr(CSR_CODE_BLOCKS, 0));
      dir_rows.push_back(with_exp(mk_word(CMD_START, 1, 0, 0, 0, 0, 0), STS_INVALID, 0, 0, 0));
      dir_rows.push_back(mk_csr(CSR_CODE_BLOCKS, 1));
      dir_rows.push_back(mk_csr(CSR_HARQ, 0));
      dir_rows.push_back(with_exp(mk_word(CMD_START, 0, 0, 0, 0, 0, 0), STS_INVALID, 0, 0, 0));
      dir_rows.push_back(mk_csr(CSR_HARQ, 15));
      dir_rows.push_back(mk_csr(CSR_MIMO, 0));
      dir_rows.push_back(with_exp(mk_word(CMD_START, 0, 0, 0, 0, 0, 0), STS_INVALID, 0, 0, 0));
      dir_rows.push_back(mk_csr(CSR_MIMO, 2));
      dir_rows.push_back(mk_csr(CSR_MOD_ORDER, 0));
      dir_rows.push_back(with_exp(mk_word(CMD_START, 0, 0, 0, 0, 0, 0), STS_INVALID, 0, 0, 0));
      dir_rows.push_back(mk_csr(CSR_MOD_ORDER, 8));
      dir_rows.push_back(mk_csr(CSR_LAYERS, 0));
      dir_rows.push_back(with_exp(mk_word(CMD_START, 0, 0, 0, 0, 0, 0), STS_INVALID, 0, 0, 0));
      dir_rows.push_back(mk_csr(CSR_LAYERS, 4));
      dir_rows.push_back(mk_csr(CSR_ROW_COUNT, 0));
      dir_rows.push_back(with_exp(mk_word(CMD_START, 0, 0, 0, 0, 0, 0), STS_INVALID, 0, 0, 0));
      dir_rows.push_back(mk_csr(CSR_ROW_COUNT, MAX_ROWS_DEF + 1));
      dir_rows.push_back(with_exp(mk_word(CMD_START, 0, 0, 0, 0, 0, 0), STS_INVALID, 0, 0, 0));
      dir_rows.push_back(mk_csr(CSR_ROW_COUNT, 1));
      dir_rows.push_back(mk_csr(CSR_SOFT_BUF, 4194303));
      dir_rows.push_back(mk_csr(CSR_TOTAL_BITS, 96));
      dir_rows.push_back(mk_word(CMD_START, 3, 0, 1, 0, 0, 0));
      dir_rows.push_back(mk_word(CMD_LOAD, 0, 0, 0, 0, 75, 1));
      dir_rows.push_back(mk_word(CMD_SAMPLE, 0, 0, 0, 32767, 0, 0));
      dir_rows.push_back(mk_word(CMD_SAMPLE, 0, 0, 0, 32767, 0, 0));
      dir_rows.push_back(mk_word(CMD_START, 2, 63, 0, 0, 0, 0));
      for (int k = 0; k < 2; k++) begin
         dir_rows.push_back(mk_word(CMD_START, 0, 0, 0, 0, 0, 0));
         dir_rows.push_back(mk_word(CMD_SAMPLE, 0, 0, 0, 32767, 0, 0));
         dir_rows.push_back(mk_word(CMD_SAMPLE, 0, 0, 0, -32768, 0, 0));
      end
      dir_rows.push_back(mk_word(CMD_READ, 0, 0, 0, 0, 2, 0));
      dir_rows.push_back(mk_word(CMD_READ, 0, 0, 0, 0, 3, 0));
      dir_rows.push_back(mk_word(CMD_LOAD, 0, 0, 0, 0, 75, 0));
      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) begin
            drain();
            write_reg(dir_rows[i].idx, dir_rows[i].data);
         end else begin
            send_word(dir_rows[i]);
         end
      end

      // random phases, each under a fresh register setting
      for (int ph = 0; ph < 7; ph++) begin
         drain();
         c_rows = (ph == 0) ? 1 : (ph == 3) ? MAX_ROWS_DEF : $urandom_range(1, 4);
         c_l = $urandom_range(1, 4);
         c_q = $urandom_range(1, 8);
         c_c = (ph == 5) ? 64 : $urandom_range(1, 4);
         c_per = $urandom_range(1, (64 / (c_l * c_q) > 1) ? 64 / (c_l * c_q) : 1);
         c_tot = c_l * c_q * (c_c * c_per + $urandom_range(0, c_c - 1));
         c_sbuf = (ph == 1) ? $urandom_range(0, 4194303) : 4194303;
         if (ph == 6) begin
            c_l = 1; c_q = 1; c_tot = 1048575;
            c_sbuf = $urandom_range(0, 2000);
         end
         write_reg(CSR_ROW_COUNT, c_rows);
         write_reg(CSR_TOTAL_BITS, c_tot);
         write_reg(CSR_CODE_BLOCKS, c_c);
         write_reg(CSR_SOFT_BUF, c_sbuf);
         write_reg(CSR_HARQ, $urandom_range(1, 15));
         write_reg(CSR_MIMO, $urandom_range(1, 2));
         write_reg(CSR_MOD_ORDER, c_q);
         write_reg(CSR_LAYERS, c_l);
         n = 0;
         did_null = 0;
         did_hold = 0;
         did_wait = 0;
         while (n < 120) begin
            // long receiver hold-off while words keep coming
            if (ph == 2 && !did_hold && n >= 10) begin
               did_hold = 1;
               hold_req = 1;
            end
            // sender waits for every outstanding result
            if (ph == 4 && !did_wait && n >= 60) begin
               did_wait = 1;
               req_valid <= 0;
               while (expected_words.size() != 0) @(posedge clock);
            end
            if (ph == 0 && !did_null && n > 20) begin
               // every position null: the sample must be dropped
               did_null = 1;
               send_word(mk_word(CMD_START, $urandom_range(0, 3), 0, 0, 0, 0, 0));
               ncb = circ_len;
               for (int i = 0; i < ncb; i++) send_word(mk_word(CMD_LOAD, 0, 0, 0, 0, i, 1));
               send_word(mk_word(CMD_SAMPLE, 0, 0, 0, $urandom_range(0, 65535), 0, 0));
               for (int i = 0; i < ncb; i++) send_word(mk_word(CMD_LOAD, 0, 0, 0, 0, i, 0));
               n += 2 * ncb + 2;
            end else if ($urandom_range(99) < 75) begin
               // well-formed block, sometimes cut short or overrun
               send_word(mk_word(CMD_START, $urandom_range(0, 3),
                                 ($urandom_range(9) == 0) ? $urandom_range(0, 63)
                                                          : $urandom_range(0, c_c - 1),
                                 $urandom_range(3) == 0, 0, 0, 0));
               ncb = circ_len;
               nsmp = (samples_left < 80) ? samples_left : 80;
               if ($urandom_range(4) == 0) nsmp += 2;
               else if ($urandom_range(4) == 0) nsmp = nsmp / 2;
               n++;
               for (int i = 0; i < nsmp; i++) begin
                  if (ncb > 0 && $urandom_range(9) == 0) begin
                     send_word(mk_word($urandom_range(0, 1) ? CMD_LOAD : CMD_READ, 0, 0, 0, 0,
                                       $urandom_range(0, ncb - 1), $urandom_range(3) == 0));
                     n++;
                  end
                  send_word(mk_word(CMD_SAMPLE, 0, 0, 0, $urandom_range(0, 65535), 0, 0));
                  n++;
               end
            end else begin
               // noise: any word with any field
               send_word(mk_word($urandom_range(0, 3), $urandom_range(0, 3),
                                 $urandom_range(0, 63), $urandom_range(0, 1),
                                 $urandom_range(0, 65535), $urandom_range(0, 32767),
                                 $urandom_range(0, 1)));
               n++;
            end
         end
      end

      req_valid <= 0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (err_cnt == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
